// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the rounding unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, outside synchronous reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent holds in the cycle after the antecedent, outside synchronous reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcrh_pkg.sv =====
// Package for the ML-DSA coefficient rounding and hint unit: types and constants.
`default_nettype none

package mcrh_pkg;

  localparam int unsigned COEF_W = 23;
  localparam int unsigned HIGH_W = 10;
  localparam int unsigned LOWS_W = 19;
  localparam int unsigned HB_W   = 6;
  localparam int unsigned T_W    = 16;
  localparam int unsigned PROD_W = 30;
  localparam int unsigned DIFF_W = 25;
  localparam int unsigned D_BITS = 13;

  localparam logic [COEF_W-1:0] Q         = 23'd8380417;
  localparam logic [COEF_W-1:0] Q_HALF    = 23'd4190208;
  localparam logic [COEF_W-1:0] TWO_G_WIDE   = 23'd523776;
  localparam logic [COEF_W-1:0] TWO_G_NARROW = 23'd190464;
  localparam logic [COEF_W-1:0] P2R_HALF  = 23'd4096;
  localparam logic [COEF_W-1:0] P2R_STEP  = 23'd8192;

  localparam logic [PROD_W-1:0] MUL_WIDE    = 30'd1025;
  localparam logic [PROD_W-1:0] MUL_NARROW  = 30'd11275;
  localparam logic [PROD_W-1:0] RND_WIDE    = 30'd2097152;
  localparam logic [PROD_W-1:0] RND_NARROW  = 30'd8388608;
  localparam logic [COEF_W:0]   ROUND_ADD   = 24'd127;

  localparam logic [HB_W-1:0] HB_MAX_NARROW = 6'd43;
  localparam logic [HB_W-1:0] MOD_WIDE      = 6'd16;
  localparam logic [HB_W-1:0] MOD_NARROW    = 6'd44;

  typedef enum logic [1:0] {
    KIND_P2R     = 2'd0,
    KIND_DECOMP  = 2'd1,
    KIND_MKHINT  = 2'd2,
    KIND_USEHINT = 2'd3
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/mldsa_coeff_round_hint_unit.sv =====
// Top level of the ML-DSA coefficient rounding and hint unit (five-stage pipeline).
`default_nettype none
`include "assert_macros.svh"

// Takes one transaction per cycle while in_ready is high, passing it through the
// pipeline stages in turn; each stage holds only while the stage
// after it is full and stalled, so bubbles close up under output back-pressure.
// Stage 1 reduces the inputs and does Power2Round and w - cs2, stage 2 adds ct0
// and forms the rounded 16-bit quotient, stage 3 runs the HighBits constant
// multiplies, stage 4 forms r - r1*2*gamma2 and the hint flag, and the output
// stage centers r0, applies the hint and selects the fields. gamma2_mode resets
// to 1 (gamma2 = (q-1)/32) and must only be written while the pipeline is empty.
module mldsa_coeff_round_hint_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire                                 cfg_gamma2_mode,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [1:0]                          in_kind,
  input  wire  [mcrh_pkg::COEF_W-1:0]         in_coef_a,
  input  wire  [mcrh_pkg::COEF_W-1:0]         in_coef_b,
  input  wire  [mcrh_pkg::COEF_W-1:0]         in_coef_c,
  input  wire                                 in_hint_in,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mcrh_pkg::HIGH_W-1:0]         out_high_part,
  output logic [mcrh_pkg::COEF_W-1:0]         out_low_mod_q,
  output logic signed [mcrh_pkg::LOWS_W-1:0]  out_low_signed,
  output logic                                out_hint_out
);

  logic mode_r;

  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1
  mcrh_pkg::kind_t            kind1_r, kind2_r, kind3_r, kind4_r;
  logic                       hint1_r, hint2_r, hint3_r, hint4_r;
  logic [mcrh_pkg::COEF_W-1:0] a1_r, a2_r, a3_r;
  logic [mcrh_pkg::COEF_W-1:0] rz1_r, c1_r;
  logic [mcrh_pkg::HIGH_W-1:0] ph1_r, ph2_r, ph3_r, ph4_r;
  logic [mcrh_pkg::COEF_W-1:0] pl1_r, pl2_r, pl3_r, pl4_r;
  // stage 2
  logic [mcrh_pkg::T_W-1:0]    t1_r, t2_r;
  // stage 3
  logic [mcrh_pkg::HB_W-1:0]   h1_r, h2_r;
  // stage 4
  logic [mcrh_pkg::HB_W-1:0]   h4_r;
  logic signed [mcrh_pkg::DIFF_W-1:0] l4_r;
  logic                        hout4_r;
  // output stage
  logic [mcrh_pkg::HIGH_W-1:0] hi5_r;
  logic [mcrh_pkg::COEF_W-1:0] lmq5_r;
  logic signed [mcrh_pkg::LOWS_W-1:0] ls5_r;
  logic                        hout5_r;

  // stage 1 logic
  logic [mcrh_pkg::COEF_W-1:0] a_c, b_c, c_c, rz_nxt, pl_nxt;
  logic [mcrh_pkg::HIGH_W-1:0] ph_nxt;
  logic [mcrh_pkg::COEF_W:0]   rz_sum;
  // stage 2 logic
  logic [mcrh_pkg::COEF_W:0]   r_sum, r_red, x1, x2, x1_rnd, x2_rnd;
  // stage 3 logic
  logic [mcrh_pkg::PROD_W-1:0] m1, m2;
  logic [mcrh_pkg::HB_W-1:0]   h1_nxt, h2_nxt;
  // stage 4 logic
  logic [mcrh_pkg::COEF_W-1:0] twog, prod;
  // output stage logic
  logic signed [mcrh_pkg::DIFF_W-1:0] l_cent;
  logic [mcrh_pkg::HB_W-1:0]   hmod, h_adj;
  logic [mcrh_pkg::HIGH_W-1:0] hi_nxt;
  logic [mcrh_pkg::COEF_W-1:0] lmq_nxt;
  logic signed [mcrh_pkg::LOWS_W-1:0] ls_nxt;
  logic                        hout_nxt;

  assign cfg_ready = 1'b1;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_gamma2_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 1: reduce, power2round, w - cs2
  always_comb begin
    a_c = (in_coef_a >= mcrh_pkg::Q) ? in_coef_a - mcrh_pkg::Q : in_coef_a;
    b_c = (in_coef_b >= mcrh_pkg::Q) ? in_coef_b - mcrh_pkg::Q : in_coef_b;
    c_c = (in_coef_c >= mcrh_pkg::Q) ? in_coef_c - mcrh_pkg::Q : in_coef_c;
    rz_sum = (a_c >= b_c) ? {1'b0, a_c} - {1'b0, b_c}
                          : {1'b0, a_c} + {1'b0, mcrh_pkg::Q} - {1'b0, b_c};
    rz_nxt = rz_sum[mcrh_pkg::COEF_W-1:0];
    ph_nxt = a_c[mcrh_pkg::COEF_W-1:mcrh_pkg::D_BITS];
    pl_nxt = {10'd0, a_c[mcrh_pkg::D_BITS-1:0]};
    if (pl_nxt > mcrh_pkg::P2R_HALF) begin
      pl_nxt = pl_nxt + mcrh_pkg::Q - mcrh_pkg::P2R_STEP;
      ph_nxt = ph_nxt + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1_r <= mcrh_pkg::kind_t'(in_kind);
      hint1_r <= in_hint_in;
      a1_r    <= a_c;
      rz1_r   <= rz_nxt;
      c1_r    <= c_c;
      ph1_r   <= ph_nxt;
      pl1_r   <= pl_nxt;
    end
  end

  // stage 2: add ct0, shift down by 7 bits rounding up
  always_comb begin
    r_sum  = {1'b0, rz1_r} + {1'b0, c1_r};
    r_red  = (r_sum >= {1'b0, mcrh_pkg::Q}) ? r_sum - {1'b0, mcrh_pkg::Q} : r_sum;
    x1     = (kind1_r == mcrh_pkg::KIND_MKHINT) ? r_red : {1'b0, a1_r};
    x2     = {1'b0, rz1_r};
    x1_rnd = x1 + mcrh_pkg::ROUND_ADD;
    x2_rnd = x2 + mcrh_pkg::ROUND_ADD;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      kind2_r <= kind1_r;
      hint2_r <= hint1_r;
      a2_r    <= a1_r;
      ph2_r   <= ph1_r;
      pl2_r   <= pl1_r;
      t1_r    <= x1_rnd[mcrh_pkg::COEF_W-1:7];
      t2_r    <= x2_rnd[mcrh_pkg::COEF_W-1:7];
    end
  end

  // stage 3: HighBits multiply-shift
  always_comb begin
    if (mode_r) begin
      m1     = {14'd0, t1_r} * mcrh_pkg::MUL_WIDE + mcrh_pkg::RND_WIDE;
      m2     = {14'd0, t2_r} * mcrh_pkg::MUL_WIDE + mcrh_pkg::RND_WIDE;
      h1_nxt = {2'b00, m1[25:22]};
      h2_nxt = {2'b00, m2[25:22]};
    end else begin
      m1     = {14'd0, t1_r} * mcrh_pkg::MUL_NARROW + mcrh_pkg::RND_NARROW;
      m2     = {14'd0, t2_r} * mcrh_pkg::MUL_NARROW + mcrh_pkg::RND_NARROW;
      h1_nxt = (m1[29:24] > mcrh_pkg::HB_MAX_NARROW) ? '0 : m1[29:24];
      h2_nxt = (m2[29:24] > mcrh_pkg::HB_MAX_NARROW) ? '0 : m2[29:24];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      kind3_r <= kind2_r;
      hint3_r <= hint2_r;
      a3_r    <= a2_r;
      ph3_r   <= ph2_r;
      pl3_r   <= pl2_r;
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
    end
  end

  // stage 4: r - r1 * 2 * gamma2, hint flag
  always_comb begin
    twog = mode_r ? mcrh_pkg::TWO_G_WIDE : mcrh_pkg::TWO_G_NARROW;
    prod = {17'd0, h1_r} * twog;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      kind4_r <= kind3_r;
      hint4_r <= hint3_r;
      ph4_r   <= ph3_r;
      pl4_r   <= pl3_r;
      h4_r    <= h1_r;
      hout4_r <= (h1_r != h2_r);
      l4_r    <= $signed({2'b00, a3_r}) - $signed({2'b00, prod});
    end
  end

  // output stage: center r0, apply hint, select fields
  always_comb begin
    l_cent = (l4_r > $signed({2'b00, mcrh_pkg::Q_HALF}))
           ? l4_r - $signed({2'b00, mcrh_pkg::Q}) : l4_r;
    hmod   = mode_r ? mcrh_pkg::MOD_WIDE : mcrh_pkg::MOD_NARROW;
    h_adj  = h4_r;
    if (hint4_r) begin
      if (l_cent > 0) begin
        h_adj = (h4_r + 6'd1 == hmod) ? '0 : h4_r + 6'd1;
      end else begin
        h_adj = (h4_r == '0) ? hmod - 6'd1 : h4_r - 6'd1;
      end
    end
    hi_nxt   = '0;
    lmq_nxt  = '0;
    ls_nxt   = '0;
    hout_nxt = 1'b0;
    case (kind4_r)
      mcrh_pkg::KIND_P2R: begin
        hi_nxt  = ph4_r;
        lmq_nxt = pl4_r;
      end
      mcrh_pkg::KIND_DECOMP: begin
        hi_nxt = {4'd0, h4_r};
        ls_nxt = l_cent[mcrh_pkg::LOWS_W-1:0];
      end
      mcrh_pkg::KIND_MKHINT: begin
        hout_nxt = hout4_r;
      end
      mcrh_pkg::KIND_USEHINT: begin
        hi_nxt = {4'd0, h_adj};
      end
      default: begin
        hi_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      hi5_r   <= hi_nxt;
      lmq5_r  <= lmq_nxt;
      ls5_r   <= ls_nxt;
      hout5_r <= hout_nxt;
    end
  end

  assign out_valid      = v5_r;
  assign out_high_part  = hi5_r;
  assign out_low_mod_q  = lmq5_r;
  assign out_low_signed = ls5_r;
  assign out_hint_out   = hout5_r;

  `ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v1_r, "accepted transaction not captured")
  `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_high_part),
               "stalled result changed")
  `ASSERT_CLK(a_lmq_range, !out_valid || (out_low_mod_q < mcrh_pkg::Q),
              "low_mod_q not reduced")
  `ASSERT_CLK(a_ls_range, !out_valid || ((out_low_signed <= 19'sd261888) &&
              (out_low_signed >= -19'sd261888)), "low_signed out of range")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the ML-DSA coefficient rounding and hint unit.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    mcrh_pkg::kind_t                    kind;
    logic [mcrh_pkg::HIGH_W-1:0]        high_part;
    logic [mcrh_pkg::COEF_W-1:0]        low_mod_q;
    logic signed [mcrh_pkg::LOWS_W-1:0] low_signed;
    logic                               hint_out;
  } rounding_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic                               cfg_gamma2_mode = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [1:0]                         in_kind = '0;
  logic [mcrh_pkg::COEF_W-1:0]        in_coef_a = '0;
  logic [mcrh_pkg::COEF_W-1:0]        in_coef_b = '0;
  logic [mcrh_pkg::COEF_W-1:0]        in_coef_c = '0;
  logic                               in_hint_in = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [mcrh_pkg::HIGH_W-1:0]        out_high_part;
  logic [mcrh_pkg::COEF_W-1:0]        out_low_mod_q;
  logic signed [mcrh_pkg::LOWS_W-1:0] out_low_signed;
  logic                               out_hint_out;

  rounding_t   rounding_due[$];
  bit          gamma2_wide = 1'b1;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatch_count = 0;

  mldsa_coeff_round_hint_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_gamma2_mode (cfg_gamma2_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_coef_a       (in_coef_a),
    .in_coef_b       (in_coef_b),
    .in_coef_c       (in_coef_c),
    .in_hint_in      (in_hint_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_high_part   (out_high_part),
    .out_low_mod_q   (out_low_mod_q),
    .out_low_signed  (out_low_signed),
    .out_hint_out    (out_hint_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned canon_coef(logic [mcrh_pkg::COEF_W-1:0] x);
    return (x >= mcrh_pkg::Q) ? x - mcrh_pkg::Q : x;
  endfunction

  function automatic int unsigned high_bits_of(int unsigned r, bit wide);
    int unsigned t;
    t = (r + mcrh_pkg::ROUND_ADD) >> 7;
    if (wide) begin
      t = (t * mcrh_pkg::MUL_WIDE + mcrh_pkg::RND_WIDE) >> 22;
      return t & 15;
    end
    t = (t * mcrh_pkg::MUL_NARROW + mcrh_pkg::RND_NARROW) >> 24;
    return (t > mcrh_pkg::HB_MAX_NARROW) ? 0 : t;
  endfunction

  function automatic void split_coef(input int unsigned r, input bit wide,
                                     output int unsigned hi, output int lo);
    hi = high_bits_of(r, wide);
    lo = int'(r) - int'(hi * (wide ? mcrh_pkg::TWO_G_WIDE : mcrh_pkg::TWO_G_NARROW));
    if (lo > int'(mcrh_pkg::Q_HALF))
      lo -= int'(mcrh_pkg::Q);
  endfunction

  function automatic rounding_t compute_rounding(mcrh_pkg::kind_t k,
                                                 logic [mcrh_pkg::COEF_W-1:0] a_raw,
                                                 logic [mcrh_pkg::COEF_W-1:0] b_raw,
                                                 logic [mcrh_pkg::COEF_W-1:0] c_raw,
                                                 logic hint, bit wide);
    rounding_t   res;
    int unsigned a, b, c, h, lmq, rz, rs, m;
    int          ls;
    a = canon_coef(a_raw);
    b = canon_coef(b_raw);
    c = canon_coef(c_raw);
    h = 0;
    lmq = 0;
    ls = 0;
    res.hint_out = 1'b0;
    case (k)
      mcrh_pkg::KIND_P2R: begin
        h = a >> mcrh_pkg::D_BITS;
        lmq = a - (h << mcrh_pkg::D_BITS);
        if (lmq > mcrh_pkg::P2R_HALF) begin
          lmq = lmq + mcrh_pkg::Q - mcrh_pkg::P2R_STEP;
          h++;
        end
      end
      mcrh_pkg::KIND_DECOMP: split_coef(a, wide, h, ls);
      mcrh_pkg::KIND_MKHINT: begin
        rz = (a >= b) ? a - b : a + mcrh_pkg::Q - b;
        rs = rz + c;
        if (rs >= mcrh_pkg::Q)
          rs -= mcrh_pkg::Q;
        res.hint_out = (high_bits_of(rs, wide) != high_bits_of(rz, wide));
      end
      default: begin
        split_coef(a, wide, h, ls);
        if (hint) begin
          m = wide ? mcrh_pkg::MOD_WIDE : mcrh_pkg::MOD_NARROW;
          if (ls > 0)
            h = (h + 1 == m) ? 0 : h + 1;
          else
            h = (h == 0) ? m - 1 : h - 1;
        end
        ls = 0;
      end
    endcase
    res.kind = k;
    res.high_part = h[mcrh_pkg::HIGH_W-1:0];
    res.low_mod_q = lmq[mcrh_pkg::COEF_W-1:0];
    res.low_signed = ls[mcrh_pkg::LOWS_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk) begin
    rounding_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rounding_due.size() == 0) begin
        report_mismatch("result transaction with none outstanding");
      end else begin
        want = rounding_due.pop_front();
        if (out_high_part !== want.high_part)
          report_mismatch($sformatf("%s high_part got %0d want %0d",
                                    want.kind.name(), out_high_part, want.high_part));
        if (out_low_mod_q !== want.low_mod_q)
          report_mismatch($sformatf("%s low_mod_q got %0d want %0d",
                                    want.kind.name(), out_low_mod_q, want.low_mod_q));
        if (out_low_signed !== want.low_signed)
          report_mismatch($sformatf("%s low_signed got %0d want %0d",
                                    want.kind.name(), out_low_signed, want.low_signed));
        if (out_hint_out !== want.hint_out)
          report_mismatch($sformatf("%s hint_out got %0b want %0b",
                                    want.kind.name(), out_hint_out, want.hint_out));
      end
    end
  end

  task automatic send_coeff(mcrh_pkg::kind_t k, logic [mcrh_pkg::COEF_W-1:0] a,
                            logic [mcrh_pkg::COEF_W-1:0] b,
                            logic [mcrh_pkg::COEF_W-1:0] c, logic hint);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_coef_a  <= a;
    in_coef_b  <= b;
    in_coef_c  <= c;
    in_hint_in <= hint;
    do @(posedge clk); while (!in_ready);
    rounding_due.push_back(compute_rounding(k, a, b, c, hint, gamma2_wide));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (rounding_due.size() != 0);
  endtask

  task automatic write_gamma2_mode(bit mode);
    cfg_valid       <= 1'b1;
    cfg_gamma2_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    gamma2_wide = mode;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [mcrh_pkg::COEF_W-1:0] rand_coef();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 23'h7FFFFF);
      1: v = $urandom_range(mcrh_pkg::Q - 64, 23'h7FFFFF);
      2: begin
        if ($urandom_range(0, 1))
          v = $urandom_range(1, 31) * (mcrh_pkg::TWO_G_WIDE / 2);
        else
          v = $urandom_range(1, 87) * (mcrh_pkg::TWO_G_NARROW / 2);
        v = v + $urandom_range(0, 600) - 300;
      end
      3: v = $urandom_range(0, 1022) * mcrh_pkg::P2R_STEP + mcrh_pkg::P2R_HALF
             + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, mcrh_pkg::Q - 1);
    endcase
    return v[mcrh_pkg::COEF_W-1:0];
  endfunction

  function automatic logic [mcrh_pkg::COEF_W-1:0] rand_ct0();
    case ($urandom_range(0, 3))
      0: return 23'($urandom_range(0, mcrh_pkg::P2R_HALF));
      1: return 23'(mcrh_pkg::Q - $urandom_range(1, mcrh_pkg::P2R_HALF));
      default: return rand_coef();
    endcase
  endfunction

  task automatic apply_directed_list();
    send_coeff(mcrh_pkg::KIND_P2R, 23'd0, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_P2R, 23'd4096, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_P2R, 23'd4097, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_P2R, mcrh_pkg::Q - 23'd1, 23'h7FFFFF, 23'h7FFFFF, 1'b1);
    send_coeff(mcrh_pkg::KIND_DECOMP, mcrh_pkg::Q - 23'd1, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_DECOMP, 23'h7FFFFF, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_DECOMP, 23'd261888, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_DECOMP, 23'd95232, 23'd0, 23'd0, 1'b0);
    send_coeff(mcrh_pkg::KIND_MKHINT, 23'd0, mcrh_pkg::Q - 23'd1, mcrh_pkg::Q - 23'd1,
               1'b0);
    send_coeff(mcrh_pkg::KIND_MKHINT, 23'h7FFFFF, 23'd0, 23'h7FFFFF, 1'b1);
    send_coeff(mcrh_pkg::KIND_USEHINT, 23'd0, 23'd0, 23'd0, 1'b1);
    send_coeff(mcrh_pkg::KIND_USEHINT, 23'd7857640, 23'd0, 23'd0, 1'b1);
    send_coeff(mcrh_pkg::KIND_USEHINT, 23'd8190952, 23'd0, 23'd0, 1'b1);
    send_coeff(mcrh_pkg::KIND_USEHINT, 23'd12345, 23'd0, 23'd0, 1'b0);
    wait_for_results();
  endtask

  task automatic apply_random_stream(int unsigned count);
    repeat (count)
      send_coeff(mcrh_pkg::kind_t'($urandom_range(0, 3)), rand_coef(), rand_coef(),
                 rand_ct0(), 1'($urandom_range(0, 1)));
    wait_for_results();
  endtask

  task automatic test_directed_reset_mode();
    apply_directed_list();
  endtask

  task automatic test_directed_narrow();
    write_gamma2_mode(1'b0);
    apply_directed_list();
  endtask

  task automatic test_random_back_to_back();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    apply_random_stream(260);
  endtask

  task automatic test_random_sender_gaps();
    write_gamma2_mode(1'b1);
    sender_idle_pct = 84;
    receiver_stall_pct = 0;
    apply_random_stream(260);
  endtask

  task automatic test_random_receiver_stalls();
    write_gamma2_mode(1'b0);
    sender_idle_pct = 0;
    receiver_stall_pct = 84;
    apply_random_stream(260);
  endtask

  task automatic test_random_mixed_idling();
    write_gamma2_mode(1'b1);
    sender_idle_pct = 18;
    receiver_stall_pct = 18;
    apply_random_stream(130);
    write_gamma2_mode(1'b0);
    apply_random_stream(130);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_reset_mode();
    test_directed_narrow();
    test_random_back_to_back();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_mixed_idling();
    in_valid <= 1'b0;
    for (int n = 0; n < 100000 && rounding_due.size() != 0; n++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (rounding_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", rounding_due.size()));
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
